>>> rtl/channel_power_limiter_core_macros.svh
// ----------------------------------------------------------------------------
// channel power limiter assertion macros
// shared concurrent assertion forms, clocked on aclk, off while in reset
// ----------------------------------------------------------------------------
`ifndef CHANNEL_POWER_LIMITER_CORE_MACROS_SVH
`define CHANNEL_POWER_LIMITER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CPL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cpl_pkg.sv
// ----------------------------------------------------------------------------
// cpl_pkg
// widths, register indexes and stage payload types of the power limiter
// ----------------------------------------------------------------------------
package cpl_pkg;

    localparam int NUM_CH  = 6;
    localparam int LEVEL_W = 8;
    localparam int LIMIT_W = 11;
    localparam int COUNT_W = 3;
    localparam int SUM_W   = LEVEL_W + $clog2(NUM_CH);
    localparam int PROD_W  = LEVEL_W + LIMIT_W;
    // scaled level is always below its input level, so it fits a level
    localparam int Q_W     = LEVEL_W;
    localparam int SHIFT_W = $clog2(Q_W);
    localparam int DATA_W  = LIMIT_W;
    localparam int IDX_W   = 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_POWER_LIMIT   = 1'd0;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

    // reset values
    localparam logic [LIMIT_W-1:0] POWER_LIMIT_RST   = 11'd1530;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 3'd6;

    // a lit channel never drops below this
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_LIT = 8'd1;

    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [NUM_CH-1:0][LEVEL_W-1:0] level_arr_t;
    typedef logic [NUM_CH-1:0][PROD_W-1:0] rem_arr_t;
    typedef logic [NUM_CH-1:0][Q_W-1:0] quo_arr_t;

    // after the summing stage
    typedef struct packed {
        level_arr_t          level;
        logic [NUM_CH-1:0]   active;
        logic [SUM_W-1:0]    sum;
        logic                over;
    } cpl_front_t;

    // through the divider stages
    typedef struct packed {
        level_arr_t          level;
        logic [NUM_CH-1:0]   scale_en;
        logic [SUM_W-1:0]    sum;
        logic                over;
        rem_arr_t            rem;
        quo_arr_t            quo;
    } cpl_div_t;

    // finished frame
    typedef struct packed {
        level_arr_t level;
        logic       limited;
    } cpl_res_t;

endpackage

>>> rtl/cpl_sum.sv
// ----------------------------------------------------------------------------
// cpl_sum
// first stage: active channel mask, sum of active levels, compare to limit
// ----------------------------------------------------------------------------
module cpl_sum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cpl_pkg::LIMIT_W-1:0]   power_limit,
    input  logic [cpl_pkg::COUNT_W-1:0]   channel_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpl_pkg::level_arr_t           in_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpl_pkg::cpl_front_t           out_data
);

    logic                         valid_reg;
    cpl_pkg::cpl_front_t          data_reg;
    cpl_pkg::cpl_front_t          data_next;
    logic [cpl_pkg::COUNT_W-1:0]  active_cnt;

    // count above the channel total acts as the total
    always_comb begin
        if (channel_count > cpl_pkg::COUNT_W'(cpl_pkg::NUM_CH)) begin
            active_cnt = cpl_pkg::COUNT_W'(cpl_pkg::NUM_CH);
        end else begin
            active_cnt = channel_count;
        end
        data_next       = '0;
        data_next.level = in_level;
        for (int i = 0; i < cpl_pkg::NUM_CH; i++) begin
            data_next.active[i] = (cpl_pkg::COUNT_W'(i) < active_cnt);
            if (data_next.active[i]) begin
                data_next.sum = data_next.sum + cpl_pkg::SUM_W'(in_level[i]);
            end
        end
        data_next.over = (data_next.sum > cpl_pkg::SUM_W'(power_limit));
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cpl_scale.sv
// ----------------------------------------------------------------------------
// cpl_scale
// second stage: per-lane product level * limit, the dividend of the scaling
// ----------------------------------------------------------------------------
module cpl_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cpl_pkg::LIMIT_W-1:0]   power_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpl_pkg::cpl_front_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpl_pkg::cpl_div_t             out_data
);

    logic               valid_reg;
    cpl_pkg::cpl_div_t  data_reg;
    cpl_pkg::cpl_div_t  data_next;

    // one 8 x 11 multiplier per lane
    always_comb begin
        data_next       = '0;
        data_next.level = in_data.level;
        data_next.sum   = in_data.sum;
        data_next.over  = in_data.over;
        for (int i = 0; i < cpl_pkg::NUM_CH; i++) begin
            data_next.scale_en[i] = in_data.active[i] && (in_data.level[i] != '0);
            data_next.rem[i]      = cpl_pkg::PROD_W'(in_data.level[i])
                                  * cpl_pkg::PROD_W'(power_limit);
        end
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cpl_div_step.sv
// ----------------------------------------------------------------------------
// cpl_div_step
// one restoring division stage: one quotient bit for every lane
// ----------------------------------------------------------------------------
module cpl_div_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  cpl_pkg::shift_t     shift,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpl_pkg::cpl_div_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpl_pkg::cpl_div_t   out_data
);

    logic                        valid_reg;
    cpl_pkg::cpl_div_t           data_reg;
    cpl_pkg::cpl_div_t           data_next;
    logic [cpl_pkg::PROD_W-1:0]  divisor;
    logic                        q_bit;

    // compare remainder with the shifted sum, subtract when it fits
    always_comb begin
        divisor   = cpl_pkg::PROD_W'(in_data.sum) << shift;
        data_next = in_data;
        q_bit     = 1'b0;
        for (int i = 0; i < cpl_pkg::NUM_CH; i++) begin
            q_bit = (in_data.rem[i] >= divisor);
            if (q_bit) begin
                data_next.rem[i] = in_data.rem[i] - divisor;
            end
            data_next.quo[i] = {in_data.quo[i][cpl_pkg::Q_W-2:0], q_bit};
        end
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cpl_out.sv
// ----------------------------------------------------------------------------
// cpl_out
// last stage: pick scaled or original level, keep lit channels lit
// ----------------------------------------------------------------------------
module cpl_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpl_pkg::cpl_div_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpl_pkg::cpl_res_t   out_data
);

    logic               valid_reg;
    cpl_pkg::cpl_res_t  data_reg;
    cpl_pkg::cpl_res_t  data_next;

    // scaled lanes take the quotient, a zero quotient becomes the minimum
    always_comb begin
        data_next.limited = in_data.over;
        for (int i = 0; i < cpl_pkg::NUM_CH; i++) begin
            if (in_data.over && in_data.scale_en[i]) begin
                if (in_data.quo[i] == '0) begin
                    data_next.level[i] = cpl_pkg::LEVEL_MIN_LIT;
                end else begin
                    data_next.level[i] = in_data.quo[i];
                end
            end else begin
                data_next.level[i] = in_data.level[i];
            end
        end
    end

    // output register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/channel_power_limiter_core.sv
// ----------------------------------------------------------------------------
// channel_power_limiter_core
// scales a six-channel LED frame down when its active sum exceeds a limit
// ----------------------------------------------------------------------------
//
//  channel   ports                               direction
//  --------  ----------------------------------  ---------
//  input     s_valid s_ready s_level_in_0..5     in
//  result    m_valid m_ready m_level_out_0..5    out
//            m_limited
//  config    cfg_we cfg_index cfg_wdata          in
//
//  one transaction per cycle sustained while m_ready stays high; eleven register
//  stages: sum, multiply, eight divider stages (one quotient bit each) and the
//  output register. the divider sets the depth. synchronous active-low reset
//  empties every stage and loads the register reset values. a stall only holds
//  stages that are full, so bubbles close up and input is taken while a finished
//  frame waits at the output.
//
`include "channel_power_limiter_core_macros.svh"

module channel_power_limiter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [cpl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cpl_pkg::DATA_W-1:0]    cfg_wdata,
    // input frame
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_0,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_1,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_2,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_3,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_4,
    input  logic [cpl_pkg::LEVEL_W-1:0]   s_level_in_5,
    // result frame
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_0,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_1,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_2,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_3,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_4,
    output logic [cpl_pkg::LEVEL_W-1:0]   m_level_out_5,
    output logic                          m_limited
);

    logic [cpl_pkg::LIMIT_W-1:0]  power_limit_reg;
    logic [cpl_pkg::COUNT_W-1:0]  channel_count_reg;

    cpl_pkg::level_arr_t          in_level;
    logic                         sum_valid;
    logic                         sum_ready;
    cpl_pkg::cpl_front_t          sum_data;
    logic                         div_valid [0:cpl_pkg::Q_W];
    logic                         div_ready [0:cpl_pkg::Q_W];
    cpl_pkg::cpl_div_t            div_data  [0:cpl_pkg::Q_W];
    cpl_pkg::cpl_res_t            res_data;

    // last divider stage as seen by the checks
    cpl_pkg::cpl_div_t            fin;
    logic [cpl_pkg::NUM_CH-1:0]   fin_en;
    logic [cpl_pkg::PROD_W-1:0]   fin_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_limit_reg   <= cpl_pkg::POWER_LIMIT_RST;
            channel_count_reg <= cpl_pkg::CHANNEL_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cpl_pkg::REG_POWER_LIMIT: begin
                    power_limit_reg <= cfg_wdata[cpl_pkg::LIMIT_W-1:0];
                end
                cpl_pkg::REG_CHANNEL_COUNT: begin
                    channel_count_reg <= cfg_wdata[cpl_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // gather the input levels
    assign in_level[0] = s_level_in_0;
    assign in_level[1] = s_level_in_1;
    assign in_level[2] = s_level_in_2;
    assign in_level[3] = s_level_in_3;
    assign in_level[4] = s_level_in_4;
    assign in_level[5] = s_level_in_5;

    // sum and compare
    cpl_sum u_sum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .power_limit   (power_limit_reg),
        .channel_count (channel_count_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_level      (in_level),
        .out_valid     (sum_valid),
        .out_ready     (sum_ready),
        .out_data      (sum_data)
    );

    // dividends
    cpl_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .power_limit (power_limit_reg),
        .in_valid    (sum_valid),
        .in_ready    (sum_ready),
        .in_data     (sum_data),
        .out_valid   (div_valid[0]),
        .out_ready   (div_ready[0]),
        .out_data    (div_data[0])
    );

    // divider, most significant quotient bit first
    for (genvar k = 0; k < cpl_pkg::Q_W; k++) begin : g_div
        cpl_div_step u_div_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (cpl_pkg::shift_t'(cpl_pkg::Q_W - 1 - k)),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // output selection and register
    cpl_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid[cpl_pkg::Q_W]),
        .in_ready  (div_ready[cpl_pkg::Q_W]),
        .in_data   (div_data[cpl_pkg::Q_W]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_data)
    );

    assign m_level_out_0 = res_data.level[0];
    assign m_level_out_1 = res_data.level[1];
    assign m_level_out_2 = res_data.level[2];
    assign m_level_out_3 = res_data.level[3];
    assign m_level_out_4 = res_data.level[4];
    assign m_level_out_5 = res_data.level[5];
    assign m_limited     = res_data.limited;

    // lanes that leave the divider scaled
    assign fin     = div_data[cpl_pkg::Q_W];
    assign fin_en  = {cpl_pkg::NUM_CH{div_valid[cpl_pkg::Q_W] && fin.over}} & fin.scale_en;
    assign fin_sum = cpl_pkg::PROD_W'(fin.sum);

    // assertions
    `CPL_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, sum_valid, "accepted frame lost")

    for (genvar i = 0; i < cpl_pkg::NUM_CH; i++) begin : g_chk
        `CPL_ASSERT_SAME(a_quo_below, fin_en[i], fin.quo[i] < fin.level[i], "quotient too large")
        `CPL_ASSERT_SAME(a_rem_below, fin_en[i], fin.rem[i] < fin_sum, "remainder too large")
    end

endmodule
